// ===== src/leb128_pkg.sv =====
// ----------------------------------------------------------------------------
// leb128_pkg
// Types shared by the LEB128 stream decoder: word layouts and status codes.
// ----------------------------------------------------------------------------
package leb128_pkg;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TRUNC   = 2'd1,
    STAT_TOO_BIG = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_signed;
    logic       last_available;
  } in_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  byte_count;
    status_t     status;
  } out_word_t;

endpackage

// ===== src/leb128_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// leb128_stream_decoder_unit
// Streaming ULEB128 / SLEB128 decoder, one byte per word, one result per
// finished value, truncation or overflow.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_data  (in_word_t)
// out      out  out_valid / out_ready  out_data (out_word_t)
//
// One byte is accepted per cycle while in_ready is high; its result is
// registered into out, or into the skid while out holds an untaken word.
// A two-entry output (result register plus skid) lets bytes keep flowing
// while a result waits; in_ready drops only when both hold. Synchronous
// active-low reset returns the decoder to idle and empties the output.
// ----------------------------------------------------------------------------
module leb128_stream_decoder_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  leb128_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output leb128_pkg::out_word_t out_data
);
  import leb128_pkg::*;

  localparam int         VB   = VALUE_BITS;
  localparam logic [8:0] VB9  = 9'(VALUE_BITS);

  logic [VB-1:0] acc_r, acc_nxt;
  logic [7:0]    sh_r, sh_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic          sgn_r, sgn_nxt;
  logic          in_value_r, in_value_nxt;

  out_word_t     out_r, out_nxt, skid_r, skid_nxt;
  logic          out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  logic          accept, res_vld;
  out_word_t     res;

  logic          sgn, neg, too_big, cont;
  logic [6:0]    slice;
  logic [7:0]    sh_new, cnt_new, rem_bits, p;
  logic [8:0]    sh_end;
  logic [6:0]    upper;
  logic [VB+6:0] placed;
  logic [VB-1:0] acc_new, fill, v;
  logic [63:0]   v_ext;

  assign in_ready  = !skid_vld_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    sgn      = in_value_r ? sgn_r : in_data.is_signed;
    slice    = in_data.data_byte[6:0];
    cont     = in_data.data_byte[7];
    neg      = acc_r[VB-1];
    sh_end   = {1'b0, sh_r} + 9'd7;
    rem_bits = 8'(VB9 - {1'b0, sh_r});
    p        = rem_bits - 8'd1;
    upper    = slice >> p;
    too_big  = 1'b0;
    if ({1'b0, sh_r} >= VB9) begin
      if (sgn) begin
        too_big = slice != (neg ? 7'h7f : 7'h00);
      end else begin
        too_big = slice != 7'h00;
      end
    end else if (sh_end > VB9) begin
      if (sgn) begin
        too_big = (upper != 7'h00) && (upper != (7'h7f >> p));
      end else begin
        too_big = (slice >> rem_bits) != 7'h00;
      end
    end

    placed  = (VB + 7)'(slice) << sh_r;
    acc_new = acc_r;
    if ({1'b0, sh_r} < VB9) begin
      acc_new = acc_r | placed[VB-1:0];
    end
    sh_new  = ({1'b0, sh_r} < VB9 + 9'd8) ? sh_r + 8'd7 : sh_r;
    cnt_new = (cnt_r != 8'hff) ? cnt_r + 8'd1 : cnt_r;

    fill = {VB{1'b1}} << sh_new;
    v    = acc_new;
    if (sgn && ({1'b0, sh_new} < VB9) && in_data.data_byte[6]) begin
      v = v | fill;
    end
    v_ext = 64'(v);
    if (sgn && v[VB-1]) begin
      v_ext = v_ext | ~64'({VB{1'b1}});
    end

    res_vld = 1'b0;
    res     = '{value: 64'd0, byte_count: cnt_new, status: STAT_OK};
    if (too_big) begin
      res_vld = 1'b1;
      res     = '{value: 64'd0, byte_count: cnt_r, status: STAT_TOO_BIG};
    end else if (cont) begin
      if (in_data.last_available) begin
        res_vld = 1'b1;
        res     = '{value: 64'd0, byte_count: cnt_new, status: STAT_TRUNC};
      end
    end else begin
      res_vld = 1'b1;
      res     = '{value: v_ext, byte_count: cnt_new, status: STAT_OK};
    end

    acc_nxt      = acc_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    sgn_nxt      = sgn_r;
    in_value_nxt = in_value_r;
    if (accept) begin
      if (res_vld) begin
        acc_nxt      = '0;
        sh_nxt       = 8'd0;
        cnt_nxt      = 8'd0;
        sgn_nxt      = 1'b0;
        in_value_nxt = 1'b0;
      end else begin
        acc_nxt      = acc_new;
        sh_nxt       = sh_new;
        cnt_nxt      = cnt_new;
        sgn_nxt      = sgn;
        in_value_nxt = 1'b1;
      end
    end

    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (skid_vld_r) begin
      if (out_ready) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (accept && res_vld) begin
      if (!out_vld_r || out_ready) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      sh_r       <= 8'd0;
      cnt_r      <= 8'd0;
      sgn_r      <= 1'b0;
      in_value_r <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      sh_r       <= sh_nxt;
      cnt_r      <= cnt_nxt;
      sgn_r      <= sgn_nxt;
      in_value_r <= in_value_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a word while output is empty");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_value_r |-> (acc_r == '0) && (sh_r == 8'd0) && (cnt_r == 8'd0))
    else $error("idle decoder holds stale state");

  a_busy_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_r |-> (sh_r != 8'd0) && (cnt_r != 8'd0))
    else $error("open value with zero shift or count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status != STAT_OK) |-> out_r.value == 64'd0)
    else $error("error result carries a nonzero value");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_vld && !skid_vld_r |=> out_vld_r)
    else $error("finished value not delivered to output");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LEB128 stream decoder. A queue of byte words
// (directed cases, then random well-formed, boundary, truncated and noisy
// sequences) feeds a valid/ready driver; every accepted word runs through a
// bit-accurate decoder model whose results are compared in order against the
// output channel, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import leb128_pkg::*;

  typedef struct packed {
    logic     hold_for_drain;
    in_word_t w;
  } tx_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  tx_item_t    byte_stream[$];
  out_word_t   pending_results[$];
  logic [7:0]  seq_q[$];
  tx_item_t    nxt;
  out_word_t   want;
  bit          drain_next = 1'b0;
  int unsigned accepted_bytes = 0;
  int unsigned tick = 0;
  int unsigned mism = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  logic [63:0] acc_val = '0;
  logic [7:0]  acc_shift = '0;
  logic [7:0]  acc_count = '0;
  logic        acc_signed = 1'b0;
  logic        acc_busy = 1'b0;

  leb128_stream_decoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic expect_word(input out_word_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    seq_q.insert(seq_q.size(), b);
  endtask

  task automatic put_item(input tx_item_t t);
    byte_stream.insert(byte_stream.size(), t);
  endtask

  task automatic decode_byte(input in_word_t w);
    logic [63:0] slice;
    logic [63:0] upper;
    logic [63:0] v;
    int unsigned sh;
    logic        too_big;
    out_word_t   r;
    if (!acc_busy) begin
      acc_val = '0;
      acc_shift = '0;
      acc_count = '0;
      acc_signed = w.is_signed;
      acc_busy = 1'b1;
    end
    slice = {57'd0, w.data_byte[6:0]};
    sh = acc_shift;
    too_big = 1'b0;
    if (!acc_signed) begin
      if (sh >= 64) too_big = (slice != 0);
      else if (sh + 7 > 64) too_big = ((slice >> (64 - sh)) != 0);
    end else if (sh >= 64) begin
      too_big = (slice != (acc_val[63] ? 64'h7f : 64'h0));
    end else if (sh + 7 > 64) begin
      upper = slice >> (63 - sh);
      too_big = (upper != 0) && (upper != (64'h7f >> (63 - sh)));
    end
    if (too_big) begin
      r.value = '0;
      r.byte_count = acc_count;
      r.status = STAT_TOO_BIG;
      expect_word(r);
      acc_busy = 1'b0;
    end else begin
      if (sh < 64) acc_val = acc_val | (slice << sh);
      if (sh < 72) sh = sh + 7;
      acc_shift = sh[7:0];
      if (acc_count != 8'd255) acc_count = acc_count + 8'd1;
      if (w.data_byte[7]) begin
        if (w.last_available) begin
          r.value = '0;
          r.byte_count = acc_count;
          r.status = STAT_TRUNC;
          expect_word(r);
          acc_busy = 1'b0;
        end
      end else begin
        v = acc_val;
        if (acc_signed && sh < 64 && w.data_byte[6]) v = v | (~64'd0 << sh);
        r.value = v;
        r.byte_count = acc_count;
        r.status = STAT_OK;
        expect_word(r);
        acc_busy = 1'b0;
      end
    end
  endtask

  task automatic encode(input logic [63:0] v, input bit sgn, input int unsigned pad);
    logic [63:0] x;
    logic [7:0]  b;
    bit          last_grp;
    x = v;
    last_grp = 1'b0;
    while (!last_grp) begin
      b = {1'b0, x[6:0]};
      if (sgn) x = $signed(x) >>> 7;
      else x = x >> 7;
      if (sgn) last_grp = (x == 0 && !b[6]) || (x == '1 && b[6]);
      else last_grp = (x == 0);
      if (!last_grp || pad != 0) b[7] = 1'b1;
      put_byte(b);
    end
    for (int k = 0; k < pad; k++)
      put_byte({(k < pad - 1), (sgn && v[63]) ? 7'h7f : 7'h00});
  endtask

  task automatic add_seq(input bit sgn, input bit last_end);
    tx_item_t t;
    for (int i = 0; i < seq_q.size(); i++) begin
      t.hold_for_drain = (i == 0) && drain_next;
      t.w.data_byte = seq_q[i];
      t.w.is_signed = (i == 0) ? sgn : 1'($urandom);
      t.w.last_available = (i == seq_q.size() - 1) ? last_end : 1'b0;
      put_item(t);
    end
    drain_next = 1'b0;
    seq_q.delete();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (byte_stream.size() != 0 &&
                     (!byte_stream[0].hold_for_drain || pending_results.size() == 0)) begin
          nxt = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.w;
          tx_gap <= ((accepted_bytes % 120) < 25) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
      tick <= 0;
    end else begin
      tick <= tick + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_bytes >= 60) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ((tick % 500) >= 100) rx_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected word: value=%h count=%0d status=%0d",
                   out_data.value, out_data.byte_count, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value || out_data.byte_count !== want.byte_count ||
            out_data.status !== want.status) begin
          mism++;
          if (mism <= 10)
            $display("mismatch: exp value=%h count=%0d status=%0d, got value=%h count=%0d status=%0d",
                     want.value, want.byte_count, want.status,
                     out_data.value, out_data.byte_count, out_data.status);
        end
      end
    end
  end

  initial begin
    logic [63:0] v;
    logic [63:0] m;
    logic [7:0]  b;
    logic [6:0]  ext;
    int unsigned nb;
    int unsigned n;
    int unsigned kind;
    bit          sgn;
    bit          long_done;
    bit          mid_drain_done;

    long_done = 1'b0;
    mid_drain_done = 1'b0;

    encode(64'd0, 1'b0, 0);              add_seq(1'b0, 1'b0);
    encode(64'd127, 1'b0, 0);            add_seq(1'b0, 1'b1);
    encode(-64'd64, 1'b1, 0);            add_seq(1'b1, 1'b0);
    encode(-64'd1, 1'b1, 0);             add_seq(1'b1, 1'b1);
    encode(64'd624485, 1'b0, 0);         add_seq(1'b0, 1'b0);
    encode(-64'd123456, 1'b1, 0);        add_seq(1'b1, 1'b0);
    put_byte(8'h80);                     add_seq(1'b0, 1'b1);
    put_byte(8'hff);                     add_seq(1'b1, 1'b1);
    // too big on a last available byte
    repeat (9) put_byte(8'hff);
    put_byte(8'h82);                     add_seq(1'b0, 1'b1);
    repeat (9) put_byte(8'h80);
    put_byte(8'h01);                     add_seq(1'b1, 1'b0);

    drain_next = 1'b1;
    while (byte_stream.size() < 650) begin
      if (!mid_drain_done && byte_stream.size() >= 300) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      sgn = $urandom;
      if (!long_done && byte_stream.size() >= 380) begin
        // count saturation
        long_done = 1'b1;
        b = sgn ? 8'hff : 8'h80;
        repeat ($urandom_range(256, 280)) put_byte(b);
        if ($urandom_range(0, 1)) begin
          put_byte({1'b0, b[6:0]});
          add_seq(sgn, 1'b0);
        end else begin
          put_byte(b);
          add_seq(sgn, 1'b1);
        end
      end else if (kind < 55) begin
        n = $urandom_range(0, 99);
        if (n < 60) nb = $urandom_range(1, 14);
        else if (n < 85) nb = $urandom_range(15, 40);
        else nb = $urandom_range(41, 64);
        v = {$urandom, $urandom};
        if (nb < 64) begin
          m = (64'd1 << nb) - 64'd1;
          v = v & m;
          if (sgn && v[nb - 1]) v = v | ~m;
        end
        encode(v, sgn, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
        add_seq(sgn, $urandom_range(0, 3) == 0);
      end else if (kind < 70) begin
        ext = $urandom_range(0, 1) ? 7'h7f : 7'h00;
        repeat (9) put_byte({1'b1, 7'($urandom)});
        n = $urandom_range(0, 3);
        for (int j = 0; j <= n; j++) begin
          if ($urandom_range(0, 4) == 0) b[6:0] = 7'($urandom);
          else if (sgn) b[6:0] = ext;
          else b[6:0] = (j == 0) ? 7'($urandom_range(0, 1)) : 7'h00;
          b[7] = (j != n);
          put_byte(b);
        end
        add_seq(sgn, $urandom_range(0, 1));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 12)) put_byte({1'b1, 7'($urandom)});
        add_seq(sgn, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          nxt.hold_for_drain = 1'b0;
          nxt.w = in_word_t'(10'($urandom));
          put_item(nxt);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_stream.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mism == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
